// ===== rtl/core/rcpwd_pkg.sv =====
// Shared types and constants for the RC pulse width decoder.
package rcpwd_pkg;

	localparam int NUM_LANES = 4;

	// Lane order, also the bit order of the pin level vector
	localparam int LANE_SPEED  = 0;
	localparam int LANE_STEER  = 1;
	localparam int LANE_MOW    = 2;
	localparam int LANE_SWITCH = 3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_US = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 8'd1;

	localparam logic [11:0] CENTER_RESET   = 12'd1500;
	localparam logic [7:0]  DEADBAND_RESET = 8'd5;

	// x/17 == (x * RECIP_17) >> RECIP_SHIFT, exact for x < 2^19
	localparam logic [19:0] RECIP_17    = 20'd986896;
	localparam int          RECIP_SHIFT = 24;

	localparam logic signed [16:0] MOW_OFFSET = 17'sd100;

	localparam int FIFO_DEPTH_DEF = 8;

	typedef struct packed {
		logic               upd;
		logic signed [15:0] value;
	} lane_res_t;

endpackage

// ===== rtl/core/rcpwd_lane.sv =====
// One pulse decode lane: edge detect, width measure, scaling and deadband.
module rcpwd_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic [31:0]         time_us,
	input  logic                level,
	input  logic [11:0]         center_us,
	input  logic [7:0]          deadband,
	output rcpwd_pkg::lane_res_t res
);
	import rcpwd_pkg::*;

	logic        last_q;
	logic [31:0] rise_q;
	logic [31:0] width;
	logic [15:0] width_sat;

	logic        fall_s1;
	logic [15:0] width_s1;
	logic        fall_s2;
	logic        neg_s2;
	logic [18:0] mag_s2;
	logic        fall_s3;
	logic        neg_s3;
	logic [38:0] prod_s3;

	logic signed [16:0] diff;
	logic [19:0]        d_x;
	logic [19:0]        d5;
	logic [19:0]        mag20;
	logic [38:0]        prod;
	logic [14:0]        quo;
	logic [15:0]        val;

	// stage 0: edge detect and width, saturated to 16 bits
	assign width = time_us - rise_q;
	assign width_sat = (|width[31:16]) ? 16'hFFFF : width[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			rise_q <= 32'd0;
			fall_s1 <= 1'b0;
			fall_s2 <= 1'b0;
			fall_s3 <= 1'b0;
		end else begin
			if (acc) begin
				last_q <= level;
				if (level && !last_q) begin
					rise_q <= time_us;
				end
			end
			fall_s1 <= acc && !level && last_q;
			fall_s2 <= fall_s1;
			fall_s3 <= fall_s2;
		end
	end

	// stage 1: (width - center) * 5, split into sign and magnitude
	assign diff = $signed({1'b0, width_s1}) - $signed({5'b0, center_us});
	assign d_x = {{3{diff[16]}}, diff};
	assign d5 = {d_x[17:0], 2'b00} + d_x;
	assign mag20 = d5[19] ? (20'd0 - d5) : d5;

	// stage 2: divide by 17 through reciprocal multiply
	assign prod = {20'd0, mag_s2} * {19'd0, RECIP_17};

	always_ff @(posedge clk) begin
		width_s1 <= width_sat;
		neg_s2 <= d5[19];
		mag_s2 <= mag20[18:0];
		neg_s3 <= neg_s2;
		prod_s3 <= prod;
	end

	// stage 3: restore sign, apply deadband
	assign quo = prod_s3[38:RECIP_SHIFT];
	always_comb begin
		if (quo < {7'd0, deadband}) begin
			val = 16'd0;
		end else if (neg_s3) begin
			val = 16'd0 - {1'b0, quo};
		end else begin
			val = {1'b0, quo};
		end
	end

	assign res.upd = fall_s3;
	assign res.value = $signed(val);

endmodule

// ===== rtl/core/rcpwd_merge.sv =====
// Held channel values, mow conversion and the result queue.
module rcpwd_merge #(
	parameter int FIFO_DEPTH = rcpwd_pkg::FIFO_DEPTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         valid_s3,
	input  rcpwd_pkg::lane_res_t [rcpwd_pkg::NUM_LANES-1:0] lane_res,
	input  logic                                         out_stall,
	output logic                                         out_valid,
	output logic                                         pop,
	output logic signed [15:0]                           speed_value,
	output logic signed [15:0]                           steer_value,
	output logic [13:0]                                  mow_value,
	output logic signed [15:0]                           switch_value
);
	import rcpwd_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

	typedef struct packed {
		logic signed [15:0] speed;
		logic signed [15:0] steer;
		logic [13:0]        mow;
		logic signed [15:0] sw;
	} held_t;

	held_t held_q;
	held_t held_nxt;
	held_t mem_q [FIFO_DEPTH];

	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic signed [16:0] mow_sum;

	assign mow_sum = {lane_res[LANE_MOW].value[15], lane_res[LANE_MOW].value} + MOW_OFFSET;

	always_comb begin
		held_nxt = held_q;
		if (lane_res[LANE_SPEED].upd) begin
			held_nxt.speed = lane_res[LANE_SPEED].value;
		end
		if (lane_res[LANE_STEER].upd) begin
			held_nxt.steer = lane_res[LANE_STEER].value;
		end
		if (lane_res[LANE_MOW].upd) begin
			held_nxt.mow = mow_sum[16] ? 14'd0 : mow_sum[14:1];
		end
		if (lane_res[LANE_SWITCH].upd) begin
			held_nxt.sw = lane_res[LANE_SWITCH].value;
		end
	end

	assign out_valid = (count_q != '0);
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (valid_s3) begin
				held_q <= held_nxt;
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (valid_s3 && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !valid_s3) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			mem_q[wr_ptr_q] <= held_nxt;
		end
	end

	assign speed_value = mem_q[rd_ptr_q].speed;
	assign steer_value = mem_q[rd_ptr_q].steer;
	assign mow_value = mem_q[rd_ptr_q].mow;
	assign switch_value = mem_q[rd_ptr_q].sw;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_W'(FIFO_DEPTH)) |-> !valid_s3)
		else $error("write into full result queue");
	a_held_only_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(valid_s3) |-> $stable(held_q))
		else $error("held values changed without an item");

endmodule

// ===== rtl/core/rc_pulse_width_decoder.sv =====
// Top level of the four channel RC servo pulse width decoder.
// Each request carries a microsecond timestamp and the pin levels of the speed,
// steer, mow and switch channels. A rising edge latches the timestamp; a falling
// edge measures the high time (mod 2^32, saturated to 65535) and decodes it as
// (width - center_us) * 5 / 17 truncated toward zero, with magnitudes under
// deadband forced to zero; mow reports max(0, (v + 100) / 2). Every request
// produces one result holding the four current values. One request is taken
// per cycle while in_stall is low; its result passes through valid_s1, valid_s2
// and valid_s3 and is written into the result queue, where it raises out_valid. The
// latency is set by the lane pipeline (width, scale, reciprocal multiply,
// deadband/merge). Requests are accepted while fewer than FIFO_DEPTH results
// are in flight or queued, so in_stall rises only after out_stall has held
// results back long enough to fill the queue. Configuration writes are always
// ready and should only be issued while the block is idle.
module rc_pulse_width_decoder #(
	parameter int FIFO_DEPTH = rcpwd_pkg::FIFO_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rcpwd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcpwd_pkg::CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [31:0]                      time_us,
	input  logic                             speed_level,
	input  logic                             steer_level,
	input  logic                             mow_level,
	input  logic                             switch_level,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [15:0]               speed_value,
	output logic signed [15:0]               steer_value,
	output logic [13:0]                      mow_value,
	output logic signed [15:0]               switch_value
);
	import rcpwd_pkg::*;

	localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

	logic [11:0]      center_q;
	logic [7:0]       deadband_q;
	logic [OCC_W-1:0] occ_q;
	logic             acc;
	logic             pop;
	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	logic [NUM_LANES-1:0] levels;
	logic [NUM_LANES-1:0] upd_vec;
	lane_res_t [NUM_LANES-1:0] lane_res;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RESET;
			deadband_q <= DEADBAND_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_CENTER_US) begin
				center_q <= cfg_data;
			end else if (cfg_index == REG_DEADBAND) begin
				deadband_q <= cfg_data[7:0];
			end
		end
	end

	// occupancy: requests accepted whose results have not been taken yet
	assign in_stall = (occ_q == OCC_W'(FIFO_DEPTH));
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (acc && !pop) begin
				occ_q <= occ_q + 1'b1;
			end else if (pop && !acc) begin
				occ_q <= occ_q - 1'b1;
			end
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// one lane per channel
	assign levels[LANE_SPEED] = speed_level;
	assign levels[LANE_STEER] = steer_level;
	assign levels[LANE_MOW] = mow_level;
	assign levels[LANE_SWITCH] = switch_level;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		rcpwd_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.acc       (acc),
			.time_us   (time_us),
			.level     (levels[i]),
			.center_us (center_q),
			.deadband  (deadband_q),
			.res       (lane_res[i])
		);
		assign upd_vec[i] = lane_res[i].upd;
	end

	rcpwd_merge #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s3     (valid_s3),
		.lane_res     (lane_res),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.pop          (pop),
		.speed_value  (speed_value),
		.steer_value  (steer_value),
		.mow_value    (mow_value),
		.switch_value (switch_value)
	);

	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(FIFO_DEPTH))
		else $error("occupancy above queue depth");
	a_upd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_vec != '0) |-> valid_s3)
		else $error("lane update without a request in flight");
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_stall && !valid_s1 && !valid_s2 && !valid_s3) |-> out_valid)
		else $error("stalled with nothing queued");
	a_pop_has_occ: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (occ_q != '0))
		else $error("result taken with no request outstanding");

endmodule
